>>> src/spf_pkg.sv
// Shared types, constants and the coil phase table of the stepper position follower.
// Used by every module of the block; depends on nothing else.
package spf_pkg;

   localparam int RING_DEPTH_DEF = 32;
   localparam int POS_SHIFT      = 5;
   localparam int CSR_ADDR_W     = 4;
   localparam int CSR_DATA_W     = 32;

   localparam logic [7:0] LOWER_LIMIT_RST = 8'd5;
   localparam logic [7:0] UPPER_LIMIT_RST = 8'd180;
   localparam logic [7:0] DEADBAND_RST    = 8'd5;

   typedef enum logic [1:0] {
      REG_LOWER_LIMIT = 2'd0,
      REG_UPPER_LIMIT = 2'd1,
      REG_DEADBAND    = 2'd2
   } reg_index_type;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_TICK   = 1'b1
   } op_type;

   typedef struct packed {
      logic       op;
      logic [7:0] sample;
      logic [7:0] target;
      logic       run;
   } req_type;

   typedef struct packed {
      logic [3:0] coils;
      logic [7:0] position;
      logic       stepped;
      logic       stop_hit;
   } rsp_type;

   typedef struct packed {
      logic [7:0] lower_limit;
      logic [7:0] upper_limit;
      logic [7:0] deadband;
   } cfg_type;

   // Half-step coil pattern for each of the eight phases.
   function automatic logic [3:0] coil_pattern(input logic [2:0] phase);
      logic [3:0] pat;
      unique case (phase)
         3'd0: pat = 4'b0001;
         3'd1: pat = 4'b0011;
         3'd2: pat = 4'b0010;
         3'd3: pat = 4'b0110;
         3'd4: pat = 4'b0100;
         3'd5: pat = 4'b1100;
         3'd6: pat = 4'b1000;
         3'd7: pat = 4'b1001;
         default: pat = 4'b0000;
      endcase
      return pat;
   endfunction

endpackage

>>> src/spf_ring.sv
// Sample ring memory with its write slot counter and per-entry valid bits.
// Depends on spf_pkg.
module spf_ring #(
   parameter int RING_DEPTH = spf_pkg::RING_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       rd_en,
   input  logic       wr_en,
   input  logic [7:0] wr_data,
   output logic [7:0] rd_data
);
   import spf_pkg::*;

   localparam int SLOT_W = $clog2(RING_DEPTH);

   logic [7:0]            mem [RING_DEPTH];
   logic [RING_DEPTH-1:0] vld_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic [SLOT_W-1:0]     wr_slot_ff;
   logic [7:0]            raw_ff;
   logic                  raw_vld_ff;

   // The slot advances when a sample's read is issued; its write lands one stage later.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff    <= '0;
         vld_ff     <= '0;
         raw_vld_ff <= 1'b0;
      end else begin
         if (rd_en) begin
            slot_ff    <= (slot_ff == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
            raw_vld_ff <= vld_ff[slot_ff];
         end
         if (wr_en) begin
            vld_ff[wr_slot_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         raw_ff     <= mem[slot_ff];
         wr_slot_ff <= slot_ff;
      end
      if (wr_en) begin
         mem[wr_slot_ff] <= wr_data;
      end
   end

   // An entry never written since reset reads as zero.
   assign rd_data = raw_vld_ff ? raw_ff : 8'd0;

endmodule

>>> src/spf_ctrl.sv
// Running sum, phase sequencer and result register of the stepper position follower.
// Depends on spf_pkg.
module spf_ctrl #(
   parameter int RING_DEPTH = spf_pkg::RING_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             item_valid,
   input  spf_pkg::req_type item,
   input  logic [7:0]       old_sample,
   input  spf_pkg::cfg_type cfg,
   output logic             take,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output spf_pkg::rsp_type rsp_data
);
   import spf_pkg::*;

   localparam int SUM_W = $clog2(RING_DEPTH * 255 + 1);
   localparam int EXT_W = (SUM_W > 8) ? SUM_W : 9;

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [2:0]       phase_ff, phase_in;
   logic [3:0]       coil_ff, coil_in;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic [7:0]       pos;
   logic [8:0]       pos_db, tgt_db;
   logic             move_down, move_up, stop;

   function automatic logic [7:0] pos_of(input logic [SUM_W-1:0] s);
      logic [EXT_W-1:0] w;
      w = EXT_W'(s) >> POS_SHIFT;
      return (|w[EXT_W-1:8]) ? 8'hFF : w[7:0];
   endfunction

   assign take = item_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      sum_in    = sum_ff;
      phase_in  = phase_ff;
      coil_in   = coil_ff;
      move_down = 1'b0;
      move_up   = 1'b0;
      stop      = 1'b0;
      pos_db    = '0;
      tgt_db    = '0;
      if (item.op == OP_SAMPLE) begin
         sum_in = sum_ff - SUM_W'(old_sample) + SUM_W'(item.sample);
         pos    = pos_of(sum_in);
      end else begin
         pos = pos_of(sum_ff);
         if (item.run) begin
            move_down = pos > item.target;
            move_up   = pos < item.target;
            pos_db    = {1'b0, pos} + {1'b0, cfg.deadband};
            tgt_db    = {1'b0, item.target} + {1'b0, cfg.deadband};
            if (move_down && pos < cfg.lower_limit) stop = 1'b1;
            if (move_up && pos > cfg.upper_limit) stop = 1'b1;
            if (pos_db > {1'b0, item.target} && {1'b0, pos} < tgt_db) stop = 1'b1;
            if (move_down || move_up) begin
               coil_in  = coil_pattern(phase_ff);
               phase_in = move_down ? phase_ff + 3'd1 : phase_ff - 3'd1;
            end
         end
      end
      rsp_data_in.coils    = coil_in;
      rsp_data_in.position = pos;
      rsp_data_in.stepped  = move_down || move_up;
      rsp_data_in.stop_hit = stop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         phase_ff     <= '0;
         coil_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            sum_ff       <= sum_in;
            phase_ff     <= phase_in;
            coil_ff      <= coil_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> src/stepper_position_follower_core.sv
// Stepper position follower: top level with the APB-style register port.
// Depends on spf_pkg, spf_ring and spf_ctrl.
// A request beat is registered in stage one, then its result in the result register.
// One item per cycle while results are taken; the ring read issued at acceptance feeds
// the running sum as the beat leaves stage one, so sample beats may follow every cycle.
// Synchronous active-high reset clears ring valid bits, sum, phase, coils; sets limits.
module stepper_position_follower_core #(
   parameter int RING_DEPTH = spf_pkg::RING_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  spf_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output spf_pkg::rsp_type                   rsp_data,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [spf_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [spf_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [spf_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import spf_pkg::*;

   // Stage one holds the accepted beat while the ring read is in flight.
   logic       s1_valid_ff;
   req_type    s1_item_ff;
   logic       take;
   logic       req_fire;
   logic       ring_rd_en;
   logic       ring_wr_en;
   logic [7:0] old_sample;
   cfg_type    cfg_ff;
   logic       csr_wr;
   reg_index_type csr_idx;

   assign req_ready  = !s1_valid_ff || take;
   assign req_fire   = req_valid && req_ready;
   // A sample's old ring entry is read as it enters and replaced as it leaves stage one.
   // Consecutive samples use consecutive slots, so a read never meets the write of the
   // same entry in one cycle.
   assign ring_rd_en = req_fire && (req_data.op == OP_SAMPLE);
   assign ring_wr_en = take && (s1_item_ff.op == OP_SAMPLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (take) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff <= req_data;
      end
   end

   spf_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (ring_rd_en),
      .wr_en   (ring_wr_en),
      .wr_data (s1_item_ff.sample),
      .rd_data (old_sample)
   );

   spf_ctrl #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .item_valid (s1_valid_ff),
      .item       (s1_item_ff),
      .old_sample (old_sample),
      .cfg        (cfg_ff),
      .take       (take),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

   // Register port: one word per register, decoded on the word address.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lower_limit <= LOWER_LIMIT_RST;
         cfg_ff.upper_limit <= UPPER_LIMIT_RST;
         cfg_ff.deadband    <= DEADBAND_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_LOWER_LIMIT: cfg_ff.lower_limit <= csr_pwdata[7:0];
            REG_UPPER_LIMIT: cfg_ff.upper_limit <= csr_pwdata[7:0];
            REG_DEADBAND:    cfg_ff.deadband    <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_LOWER_LIMIT: csr_prdata = {24'd0, cfg_ff.lower_limit};
         REG_UPPER_LIMIT: csr_prdata = {24'd0, cfg_ff.upper_limit};
         REG_DEADBAND:    csr_prdata = {24'd0, cfg_ff.deadband};
         default:         csr_prdata = '0;
      endcase
   end

endmodule
